// ----- src/vnfc_pkg.sv -----
`default_nettype none
package vnfc_pkg;
    localparam logic [31:0] FREQ_Q16  = 32'd3277;
    localparam logic [31:0] SEED_STEP = 32'd1000;
    localparam logic [31:0] HASH_M1   = 32'd15731;
    localparam logic [31:0] HASH_A1   = 32'd789221;
    localparam logic [31:0] HASH_A2   = 32'd1376312589;

    localparam logic [2:0] REG_SEED   = 3'd0;
    localparam logic [2:0] REG_COUNT  = 3'd1;
    localparam logic [2:0] REG_THR_LO = 3'd2;
    localparam logic [2:0] REG_THR_HI = 3'd3;
    localparam logic [2:0] REG_LABELS = 3'd4;

    function automatic logic [31:0] hash_pre(input logic [31:0] ix, input logic [31:0] iy,
                                             input logic [31:0] s);
        logic [31:0] n;
        n = ix + iy * 32'd57 + s * 32'd131;
        return (n << 13) ^ n;
    endfunction
endpackage
`default_nettype wire

// ----- src/vnfc_octave_cell.sv -----
`default_nettype none
// one octave: 8 register stages; passes accumulator and coordinates to the next cell
module vnfc_octave_cell #(
    parameter int COORD_BITS = 12,
    parameter int K = 0,
    parameter int OCTAVES = 4
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [31:0]           i_seed,
    input  wire logic [COORD_BITS-1:0] i_x,
    input  wire logic [COORD_BITS-1:0] i_y,
    input  wire logic [23:0]           i_acc,
    output logic      [COORD_BITS-1:0] o_x,
    output logic      [COORD_BITS-1:0] o_y,
    output logic      [23:0]           o_acc
);
    localparam int D = 8;
    localparam int PW = COORD_BITS + 12 + K;

    logic [COORD_BITS-1:0] r_x [D];
    logic [COORD_BITS-1:0] r_y [D];
    logic [23:0]           r_acc [D];

    logic [PW-1:0] w_px, w_py;
    logic [15:0] r_fx, r_fy;
    logic [31:0] r_h [4];
    logic [31:0] r_hh1 [4];
    logic [31:0] r_hh [4];
    logic [31:0] r_n2 [4];
    logic [31:0] r_n3 [4];
    logic [31:0] r_n4 [4];
    logic [15:0] r_v [4];
    logic [32:0] r_ffx, r_ffy;
    logic [17:0] r_tx, r_ty;
    logic [16:0] r_sx, r_sy, r_sy2, r_sy3, r_sy4;
    logic [16:0] r_sx2, r_sx3;
    logic [16:0] r_b0, r_b1;
    logic [15:0] r_fin;

    assign w_px = PW'(({{(PW-COORD_BITS){1'b0}}, i_x} * PW'(vnfc_pkg::FREQ_Q16)) << K);
    assign w_py = PW'(({{(PW-COORD_BITS){1'b0}}, i_y} * PW'(vnfc_pkg::FREQ_Q16)) << K);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            logic [31:0] ix, iy, s;
            logic [33:0] ax, ay;
            ix = 32'(w_px >> 16);
            iy = 32'(w_py >> 16);
            s  = i_seed + 32'(K) * vnfc_pkg::SEED_STEP;
            r_h[0] <= vnfc_pkg::hash_pre(ix, iy, s);
            r_h[1] <= vnfc_pkg::hash_pre(ix + 32'd1, iy, s);
            r_h[2] <= vnfc_pkg::hash_pre(ix, iy + 32'd1, s);
            r_h[3] <= vnfc_pkg::hash_pre(ix + 32'd1, iy + 32'd1, s);
            r_fx <= w_px[15:0];
            r_fy <= w_py[15:0];
            for (int c = 0; c < 4; c++) begin
                r_n2[c] <= r_h[c] * r_h[c];
                r_n3[c] <= r_n2[c] * vnfc_pkg::HASH_M1 + vnfc_pkg::HASH_A1;
                r_n4[c] <= r_n3[c] * r_hh[c];
                r_v[c]  <= 16'(((r_n4[c] + vnfc_pkg::HASH_A2) & 32'h7fffffff) >> 15);
            end
            r_ffx <= 33'({16'd0, r_fx} * {16'd0, r_fx});
            r_ffy <= 33'({16'd0, r_fy} * {16'd0, r_fy});
            r_tx  <= 18'(18'd196608 - {1'b0, r_fx, 1'b0});
            r_ty  <= 18'(18'd196608 - {1'b0, r_fy, 1'b0});
            ax = 34'(({17'd0, r_ffx} * {32'd0, r_tx}) >> 32);
            ay = 34'(({17'd0, r_ffy} * {32'd0, r_ty}) >> 32);
            r_sx <= 17'(ax);
            r_sy <= 17'(ay);
            r_sx2 <= r_sx;
            r_sx3 <= r_sx2;
            r_sy2 <= r_sy;
            r_sy3 <= r_sy2;
            r_sy4 <= r_sy3;
            r_b0 <= 17'((34'(r_v[0]) * 34'(17'd65536 - r_sx3) + 34'(r_v[1]) * 34'(r_sx3)) >> 16);
            r_b1 <= 17'((34'(r_v[2]) * 34'(17'd65536 - r_sx3) + 34'(r_v[3]) * 34'(r_sx3)) >> 16);
            r_fin <= 16'((34'(r_b0) * 34'(17'd65536 - r_sy4) + 34'(r_b1) * 34'(r_sy4)) >> 16);
            r_x[0] <= i_x;
            r_y[0] <= i_y;
            r_acc[0] <= i_acc;
            for (int j = 1; j < D; j++) begin
                r_x[j] <= r_x[j-1];
                r_y[j] <= r_y[j-1];
            end
            for (int j = 1; j < D - 1; j++) begin
                r_acc[j] <= r_acc[j-1];
            end
            r_acc[D-1] <= r_acc[D-2] + 24'({8'd0, r_fin} << (OCTAVES - 1 - K));
        end
    end

    // hash pipe alignment: keep n alongside n*n path
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int c = 0; c < 4; c++) begin
                r_hh1[c] <= r_h[c];
                r_hh[c]  <= r_hh1[c];
            end
        end
    end

    assign o_x = r_x[D-1];
    assign o_y = r_y[D-1];
    assign o_acc = r_acc[D-1];
endmodule
`default_nettype wire

// ----- src/value_noise_fbm_classifier.sv -----
`default_nettype none
// Pipeline: the octave cell chain, then a rounding register and a normalise and classify register.
// Throughput: one word per cycle; the octave cell chain advances on every cycle
// in which the output register is free or being taken.
// Reset: synchronous active-low; registers return to seed 0, level_count 1,
// thresholds and labels 0, and the pipeline empties.
module value_noise_fbm_classifier #(
    parameter int OCTAVES = 4,
    parameter int COORD_BITS = 12,
    parameter int MAX_LEVELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // cell_x[11:0], cell_y[23:12]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [23:0] m_axis_tdata,  // label[6:0], noise_value[22:7], zero[23]
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready
);
    localparam int LAT = 8 * OCTAVES + 2;
    localparam logic [23:0] DIV = 24'((1 << OCTAVES) - 1);
    localparam logic [32:0] RECIP = 33'(((64'd1 << 32) + 64'(DIV) - 64'd1) / 64'(DIV));

    logic [31:0] r_seed;
    logic [3:0]  r_count;
    logic [63:0] r_thr_lo, r_thr_hi, r_labels;
    logic [2:0]  w_idx;
    logic        w_en;
    logic [LAT-1:0] r_vld;

    assign pready = 1'b1;
    assign w_idx = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0; r_count <= 4'd1; r_thr_lo <= '0; r_thr_hi <= '0; r_labels <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_idx)
                vnfc_pkg::REG_SEED:   r_seed <= pwdata[31:0];
                vnfc_pkg::REG_COUNT:  r_count <= pwdata[3:0];
                vnfc_pkg::REG_THR_LO: r_thr_lo <= pwdata;
                vnfc_pkg::REG_THR_HI: r_thr_hi <= pwdata;
                vnfc_pkg::REG_LABELS: r_labels <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            vnfc_pkg::REG_SEED:   prdata = {32'd0, r_seed};
            vnfc_pkg::REG_COUNT:  prdata = {60'd0, r_count};
            vnfc_pkg::REG_THR_LO: prdata = r_thr_lo;
            vnfc_pkg::REG_THR_HI: prdata = r_thr_hi;
            vnfc_pkg::REG_LABELS: prdata = r_labels;
            default:              prdata = '0;
        endcase
    end

    assign w_en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = w_en;

    logic [COORD_BITS-1:0] w_x [OCTAVES+1];
    logic [COORD_BITS-1:0] w_y [OCTAVES+1];
    logic [23:0]           w_acc [OCTAVES+1];
    assign w_x[0] = COORD_BITS'(s_axis_tdata[11:0]);
    assign w_y[0] = COORD_BITS'(s_axis_tdata[23:12]);
    assign w_acc[0] = '0;

    for (genvar k = 0; k < OCTAVES; k++) begin : g_oct
        vnfc_octave_cell #(.COORD_BITS(COORD_BITS), .K(k), .OCTAVES(OCTAVES)) u_cell (
            .i_clk(i_clk), .i_en(w_en), .i_seed(r_seed),
            .i_x(w_x[k]), .i_y(w_y[k]), .i_acc(w_acc[k]),
            .o_x(w_x[k+1]), .o_y(w_y[k+1]), .o_acc(w_acc[k+1]));
    end

    logic [23:0] r_acc;
    logic [15:0] r_noise;
    logic [6:0]  r_label;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[LAT-2:0], s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            logic [56:0] prod;
            logic [23:0] q;
            logic [6:0]  lb;
            logic [3:0]  cnt;
            logic [15:0] th;
            r_acc <= w_acc[OCTAVES] + (DIV >> 1);
            prod = {33'd0, r_acc} * {24'd0, RECIP};
            q = prod[55:32];
            if (q > 24'hFFFF) q = 24'hFFFF;
            r_noise <= q[15:0];
            cnt = (r_count > 4'(MAX_LEVELS)) ? 4'(MAX_LEVELS) : r_count;
            lb = r_labels[6:0];
            for (int i = 0; i < MAX_LEVELS; i++) begin
                th = (i < 4) ? r_thr_lo[(i%4)*16 +: 16] : r_thr_hi[(i%4)*16 +: 16];
                if (4'(i) < cnt && q[15:0] >= th) lb = r_labels[i*8 +: 7];
            end
            r_label <= lb;
        end
    end

    assign m_axis_tvalid = r_vld[LAT-1];
    assign m_axis_tdata = {1'b0, r_noise, r_label};

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)) else $error("hold");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready) else $error("ready");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |=> $stable(r_vld)) else $error("stall");
`endif
endmodule
`default_nettype wire
